@@ src/lph_pkg.sv @@
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants
// Codes, widths and the command/status bundles of the probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

   localparam int SLOTS   = 256;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int SIZE_W  = SLOT_W + 1;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int CNT_W   = 5;
   localparam int HASH_MUL = 67;
   localparam int HASH_SUB = 113;
   localparam int KEY_BYTES = 4;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RS_OK       = 2'd0,
      RS_NOTFOUND = 2'd1,
      RS_FULL     = 2'd2,
      RS_SPARE    = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      SL_EMPTY = 2'd0,
      SL_USED  = 2'd1,
      SL_TOMB  = 2'd2,
      SL_SPARE = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      RK_FOUND    = 2'd0,
      RK_SLOT     = 2'd1,
      RK_NOTFOUND = 2'd2,
      RK_FULL     = 2'd3
   } res_kind_type;

   typedef struct packed {
      logic         load;
      logic         hash_step;
      logic         mod_step;
      logic         home_load;
      logic         probe_next;
      logic         probe_restart;
      logic         wr_tomb;
      logic         wr_insert;
      logic         res_set;
      res_kind_type res_kind;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic   hash_last;
      logic   mod_last;
      logic   slot_used;
      logic   slot_empty;
      logic   key_match;
      logic   probe_last;
      op_type op;
   } stat_type;

endpackage

`default_nettype wire

@@ src/lph_if.sv @@
// ----------------------------------------------------------------------------
// lph_if: request and response channels
// Valid/ready channels carrying one table operation and its answer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lph_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     opcode;
   logic [lph_pkg::KEY_W-1:0]      key;
   logic [lph_pkg::VAL_W-1:0]      value_in;

   modport source (output valid, output opcode, output key, output value_in, input ready);
   modport sink   (input valid, input opcode, input key, input value_in, output ready);
endinterface

interface lph_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [lph_pkg::VAL_W-1:0]      value_out;
   logic [7:0]                     slot_index;

   modport source (output valid, output status, output value_out, output slot_index,
                   input ready);
   modport sink   (input valid, input status, input value_out, input slot_index,
                   output ready);
endinterface

`default_nettype wire

@@ src/lph_ram.sv @@
// ----------------------------------------------------------------------------
// lph_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/lph_datapath.sv @@
// ----------------------------------------------------------------------------
// lph_datapath: hash, modulo and probe datapath
// Hash and remainder registers, probe pointer, slot stores and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lph_pkg::cmd_type              cmd,
   output lph_pkg::stat_type                  stat,
   input  wire logic                          csr_wr_en,
   input  wire logic [lph_pkg::SIZE_W-1:0]    csr_wr_data,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [lph_pkg::KEY_W-1:0]     req_key,
   input  wire logic [lph_pkg::VAL_W-1:0]     req_value_in,
   output logic      [1:0]                    rsp_status,
   output logic      [lph_pkg::VAL_W-1:0]     rsp_value_out,
   output logic      [7:0]                    rsp_slot_index
);

   localparam int SW = lph_pkg::SLOT_W;
   localparam int ZW = lph_pkg::SIZE_W;

   logic [ZW-1:0]               size_ff;
   logic [ZW-1:0]               size_act;
   lph_pkg::op_type             op_ff;
   logic [lph_pkg::KEY_W-1:0]   key_ff;
   logic [lph_pkg::VAL_W-1:0]   val_ff;
   logic [31:0]                 h_ff, h_in;
   logic [ZW-1:0]               rem_ff, rem_in;
   logic [lph_pkg::CNT_W-1:0]   cnt_ff;
   logic [SW-1:0]               home_ff, idx_ff, idx_in;
   logic [ZW-1:0]               n_ff;
   logic [lph_pkg::SLOTS-1:0]   valid_ff;
   logic                        valid_rd_ff;
   logic [1:0]                  res_status_ff, out_status_ff;
   logic [lph_pkg::VAL_W-1:0]   res_value_ff, out_value_ff;
   logic [SW-1:0]               res_slot_ff, out_slot_ff;

   logic [7:0]                  hbyte;
   logic [31:0]                 hbyte_sx;
   logic [ZW:0]                 rem_sh;
   logic [ZW:0]                 idx_p1;
   logic                        st_wr;
   logic [1:0]                  st_wdata;
   logic [lph_pkg::KEY_W-1:0]   key_rd;
   logic [lph_pkg::VAL_W-1:0]   val_rd;
   logic [1:0]                  st_rd;

   // Clamp the configured size into 1..SLOTS
   always_comb begin
      if (size_ff == '0) begin
         size_act = ZW'(1);
      end else if (size_ff > ZW'(lph_pkg::SLOTS)) begin
         size_act = ZW'(lph_pkg::SLOTS);
      end else begin
         size_act = size_ff;
      end
   end

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    hbyte = key_ff[7:0];
         2'd1:    hbyte = key_ff[15:8];
         2'd2:    hbyte = key_ff[23:16];
         default: hbyte = key_ff[31:24];
      endcase
      hbyte_sx = {{24{hbyte[7]}}, hbyte};
      rem_sh   = {rem_ff, h_ff[31]};
      idx_p1   = (ZW+1)'(idx_ff) + (ZW+1)'(1);
   end

   always_comb begin
      h_in   = h_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         h_in   = '0;
         rem_in = '0;
      end else if (cmd.hash_step) begin
         h_in = h_ff * 32'(lph_pkg::HASH_MUL) + hbyte_sx - 32'(lph_pkg::HASH_SUB);
      end else if (cmd.mod_step) begin
         h_in = {h_ff[30:0], 1'b0};
         if (rem_sh >= {1'b0, size_act}) begin
            rem_in = ZW'(rem_sh - {1'b0, size_act});
         end else begin
            rem_in = rem_sh[ZW-1:0];
         end
      end
   end

   // Load the home slot, restart at it, or advance with wrap at the active size
   always_comb begin
      idx_in = idx_ff;
      if (cmd.home_load) begin
         idx_in = rem_ff[SW-1:0];
      end else if (cmd.probe_restart) begin
         idx_in = home_ff;
      end else if (cmd.probe_next) begin
         idx_in = (idx_p1 >= {1'b0, size_act}) ? '0 : idx_p1[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= ZW'(lph_pkg::SLOTS);
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         if (st_wr) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.hash_step && stat.hash_last) begin
            cnt_ff <= '0;
         end else if (cmd.hash_step || cmd.mod_step) begin
            cnt_ff <= cnt_ff + lph_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= lph_pkg::op_type'(req_opcode);
         key_ff <= req_key;
         val_ff <= req_value_in;
      end
      h_ff        <= h_in;
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      valid_rd_ff <= valid_ff[idx_ff];
      if (cmd.home_load) begin
         home_ff <= rem_ff[SW-1:0];
      end
      if (cmd.home_load || cmd.probe_restart) begin
         n_ff <= '0;
      end else if (cmd.probe_next) begin
         n_ff <= n_ff + ZW'(1);
      end
      if (cmd.res_set) begin
         case (cmd.res_kind)
            lph_pkg::RK_FOUND: begin
               res_status_ff <= lph_pkg::RS_OK;
               res_value_ff  <= val_rd;
               res_slot_ff   <= idx_ff;
            end
            lph_pkg::RK_SLOT: begin
               res_status_ff <= lph_pkg::RS_OK;
               res_value_ff  <= '0;
               res_slot_ff   <= idx_ff;
            end
            lph_pkg::RK_FULL: begin
               res_status_ff <= lph_pkg::RS_FULL;
               res_value_ff  <= '0;
               res_slot_ff   <= '0;
            end
            default: begin
               res_status_ff <= lph_pkg::RS_NOTFOUND;
               res_value_ff  <= '0;
               res_slot_ff   <= '0;
            end
         endcase
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
         out_slot_ff   <= res_slot_ff;
      end
   end

   assign st_wr    = cmd.wr_tomb || cmd.wr_insert;
   assign st_wdata = cmd.wr_insert ? lph_pkg::SL_USED : lph_pkg::SL_TOMB;

   lph_ram #(.WIDTH(lph_pkg::KEY_W), .DEPTH(lph_pkg::SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_insert),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   lph_ram #(.WIDTH(lph_pkg::VAL_W), .DEPTH(lph_pkg::SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_insert),
      .wr_addr (idx_ff),
      .wr_data (val_ff),
      .rd_addr (idx_ff),
      .rd_data (val_rd)
   );

   lph_ram #(.WIDTH(2), .DEPTH(lph_pkg::SLOTS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (idx_ff),
      .wr_data (st_wdata),
      .rd_addr (idx_ff),
      .rd_data (st_rd)
   );

   assign stat.hash_last  = (cnt_ff == lph_pkg::CNT_W'(lph_pkg::KEY_BYTES - 1));
   assign stat.mod_last   = (cnt_ff == '1);
   assign stat.slot_used  = valid_rd_ff && (st_rd == lph_pkg::SL_USED);
   assign stat.slot_empty = !valid_rd_ff || (st_rd == lph_pkg::SL_EMPTY);
   assign stat.key_match  = (key_rd == key_ff);
   assign stat.probe_last = (n_ff == size_act - ZW'(1));
   assign stat.op         = op_ff;

   assign rsp_status     = out_status_ff;
   assign rsp_value_out  = out_value_ff;
   assign rsp_slot_index = 8'(out_slot_ff);

endmodule

`default_nettype wire

@@ src/lph_ctrl.sv @@
// ----------------------------------------------------------------------------
// lph_ctrl: operation sequencer
// Steps hash, modulo and the probe phases; owns the channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lph_pkg::cmd_type       cmd,
   input  wire lph_pkg::stat_type stat
);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_HASH  = 11'b000_0000_0010,
      S_MOD   = 11'b000_0000_0100,
      S_START = 11'b000_0000_1000,
      S_LK_RD = 11'b000_0001_0000,
      S_LK_CK = 11'b000_0010_0000,
      S_RM_RD = 11'b000_0100_0000,
      S_RM_CK = 11'b000_1000_0000,
      S_IN_RD = 11'b001_0000_0000,
      S_IN_CK = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_last) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.home_load = 1'b1;
            case (stat.op)
               lph_pkg::OP_LOOKUP: state_in = S_LK_RD;
               lph_pkg::OP_INSERT: state_in = S_RM_RD;
               lph_pkg::OP_REMOVE: state_in = S_RM_RD;
               default: begin
                  cmd.res_set  = 1'b1;
                  cmd.res_kind = lph_pkg::RK_NOTFOUND;
                  state_in     = S_DONE;
               end
            endcase
         end
         S_LK_RD: state_in = S_LK_CK;
         S_LK_CK: begin
            if (stat.slot_empty) begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = lph_pkg::RK_NOTFOUND;
               state_in     = S_DONE;
            end else if (stat.slot_used && stat.key_match) begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = lph_pkg::RK_FOUND;
               state_in     = S_DONE;
            end else if (stat.probe_last) begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = lph_pkg::RK_NOTFOUND;
               state_in     = S_DONE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_LK_RD;
            end
         end
         S_RM_RD: state_in = S_RM_CK;
         S_RM_CK: begin
            if (stat.slot_used && stat.key_match) begin
               cmd.wr_tomb = 1'b1;
               if (stat.op == lph_pkg::OP_REMOVE) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_kind = lph_pkg::RK_SLOT;
                  state_in     = S_DONE;
               end else begin
                  cmd.probe_restart = 1'b1;
                  state_in          = S_IN_RD;
               end
            end else if (stat.probe_last) begin
               if (stat.op == lph_pkg::OP_REMOVE) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_kind = lph_pkg::RK_NOTFOUND;
                  state_in     = S_DONE;
               end else begin
                  cmd.probe_restart = 1'b1;
                  state_in          = S_IN_RD;
               end
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_RM_RD;
            end
         end
         S_IN_RD: state_in = S_IN_CK;
         S_IN_CK: begin
            if (!stat.slot_used) begin
               cmd.wr_insert = 1'b1;
               cmd.res_set   = 1'b1;
               cmd.res_kind  = lph_pkg::RK_SLOT;
               state_in      = S_DONE;
            end else if (stat.probe_last) begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = lph_pkg::RK_FULL;
               state_in     = S_DONE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_IN_RD;
            end
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ src/linear_probe_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table
// 256-slot key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         opcode[1:0], key[31:0], value_in[31:0]
//  rsp      out        status[1:0], value_out[31:0], slot_index[7:0]
//  csr      in         wr_en, wr_data[8:0] (table size)
//
//  One request at a time: hashing one key byte a cycle, a bit-serial
//  remainder by the table size, a start state that sets the home slot,
//  then a read state and a check state per slot probed through the
//  registered-read slot RAMs; insert runs a removal ring and then a
//  placement ring.
//  Synchronous reset empties every slot at once through per-slot valid
//  flags and sets the table size to 256; no clearing pass is needed.
//  A finished response waits in its own register, so a new request is
//  taken while the previous response is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lph_req_if.sink                         req,
   lph_rsp_if.source                       rsp,
   input  wire logic                       csr_wr_en,
   input  wire logic [lph_pkg::SIZE_W-1:0] csr_wr_data
);

   lph_pkg::cmd_type  cmd;
   lph_pkg::stat_type stat;

   // sequence the operation
   lph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // hash, reduce, probe and hold the result
   lph_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_opcode     (req.opcode),
      .req_key        (req.key),
      .req_value_in   (req.value_in),
      .rsp_status     (rsp.status),
      .rsp_value_out  (rsp.value_out),
      .rsp_slot_index (rsp.slot_index)
   );

endmodule

`default_nettype wire
